### design/tgtd_pkg.sv
// Shared types and constants of the tandem Goertzel tone detector.
`default_nettype none

package tgtd_pkg;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int COEFF_FRAC    = 14;
   localparam int COUNT_BITS    = 18;
   localparam int RATIO_BITS    = 32;
   localparam int DIGIT_BITS    = 8;
   localparam int DIV_CNT_BITS  = 5;

   localparam logic [CSR_IDX_BITS-1:0]  CSR_TONE_COEFF  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0]  CSR_BLOCK_LEN   = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0] BLOCK_LEN_RESET = 16'd256;

   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_LOAD  = 4'd1,
      OP_MUL   = 4'd2,
      OP_UPD0  = 4'd3,
      OP_UPD1  = 4'd4,
      OP_UCALC = 4'd5,
      OP_QSAVE = 4'd6,
      OP_QADD  = 4'd7,
      OP_DEN   = 4'd8,
      OP_CHECK = 4'd9,
      OP_DIV   = 4'd10,
      OP_OUT   = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      A_S1_BANK0  = 3'd0,
      A_S1_BANK1  = 3'd1,
      A_S2_ACTIVE = 3'd2,
      A_U         = 3'd3,
      A_ENERGY    = 3'd4
   } a_sel_type;

   typedef enum logic [1:0] {
      B_COEFF     = 2'd0,
      B_S1_ACTIVE = 2'd1,
      B_S2_ACTIVE = 2'd2,
      B_COUNT     = 2'd3
   } b_sel_type;

   typedef struct packed {
      op_type    op;
      a_sel_type a_sel;
      b_sel_type b_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_last;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

### design/tgtd_datapath.sv
// Datapath: registers, resonator banks, shared digit multiplier and divider.
`default_nettype none

module tgtd_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int STATE_BITS  = 48
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [tgtd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [tgtd_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_sample,
   input  wire tgtd_pkg::dp_cmd_type              cmd,
   output tgtd_pkg::dp_status_type                status,
   output logic [tgtd_pkg::RATIO_BITS-1:0]        rsp_power_ratio,
   output logic                                   rsp_bank_in_use
);
   import tgtd_pkg::*;

   localparam int SB  = STATE_BITS;
   localparam int XB  = SAMPLE_BITS;
   localparam int AW  = SB + 16;
   localparam int BD  = (SB + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int BW  = BD * DIGIT_BITS;
   localparam int PW  = AW + BW;
   localparam int KW  = $clog2(BD);
   localparam int QW  = 2 * SB + 16;
   localparam int NW  = QW + 2;
   localparam int DW  = SB + COUNT_BITS;
   localparam int SQW = 2 * XB;
   localparam int EXW = ((SB > SQW) ? SB : SQW) + 1;
   localparam int TW  = SB + 3;

   logic signed [CSR_DATA_BITS-1:0] coeff_ff, coeff_in;
   logic [CSR_DATA_BITS-1:0]        blen_ff, blen_in;
   logic signed [XB-1:0]            x_ff, x_in;
   logic [SQW-1:0]                  sq_ff, sq_in;
   logic [CSR_DATA_BITS-1:0]        pos_ff, pos_in;
   logic                            act_ff, act_in;
   logic signed [SB-1:0]            s1_ff [2];
   logic signed [SB-1:0]            s1_in [2];
   logic signed [SB-1:0]            s2_ff [2];
   logic signed [SB-1:0]            s2_in [2];
   logic [SB-1:0]                   en_ff [2];
   logic [SB-1:0]                   en_in [2];
   logic [COUNT_BITS-1:0]           cnt_ff [2];
   logic [COUNT_BITS-1:0]           cnt_in [2];
   logic [KW-1:0]                   k_ff, k_in;
   logic signed [PW-1:0]            acc_ff, acc_in;
   logic signed [AW-1:0]            u_ff, u_in;
   logic signed [QW-1:0]            q_ff, q_in;
   logic [DW-1:0]                   den_ff, den_in;
   logic [NW-1:0]                   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [RATIO_BITS-1:0]           quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0]         dk_ff, dk_in;
   logic                            neg_ff, neg_in, sat_ff, sat_in;
   logic [RATIO_BITS-1:0]           ratio_ff, ratio_in;
   logic                            bank_ff, bank_in;

   // active bank views
   logic signed [SB-1:0]  s1_act, s2_act;
   logic [SB-1:0]         en_act, en_one;
   logic [COUNT_BITS-1:0] cnt_act;

   // multiplier
   logic signed [AW-1:0]         a_op;
   logic signed [BW-1:0]         b_op;
   logic [KW-1:0]                last_k;
   logic                         mul_last;
   logic [DIGIT_BITS-1:0]        digit;
   logic signed [DIGIT_BITS:0]   d9;
   logic signed [AW+DIGIT_BITS:0] partial;
   logic signed [PW-1:0]         part_sh;

   // bank update
   logic                  ub;
   logic signed [SB-1:0]  s1_u, s2_u, s_new;
   logic [SB-1:0]         en_u, e_new;
   logic [COUNT_BITS-1:0] cnt_u, cnt_new;
   logic signed [PW-1:0]  acc_sh;
   logic signed [TW-1:0]  t_sum;
   logic                  t_ovf;
   logic [EXW-1:0]        e_sum;

   // block position, divider
   logic [CSR_DATA_BITS:0] pos_p1;
   logic                   sw;
   logic signed [SQW-1:0]  sq_prod;
   logic [NW-1:0]          num;
   logic                   ge;

   assign s1_act  = act_ff ? s1_ff[1]  : s1_ff[0];
   assign s2_act  = act_ff ? s2_ff[1]  : s2_ff[0];
   assign en_act  = act_ff ? en_ff[1]  : en_ff[0];
   assign cnt_act = act_ff ? cnt_ff[1] : cnt_ff[0];
   assign en_one  = (en_act == '0) ? SB'(1) : en_act;

   always_comb begin
      case (cmd.a_sel)
         A_S1_BANK0:  a_op = AW'(s1_ff[0]);
         A_S1_BANK1:  a_op = AW'(s1_ff[1]);
         A_S2_ACTIVE: a_op = AW'(s2_act);
         A_U:         a_op = u_ff;
         A_ENERGY:    a_op = $signed({{(AW-SB){1'b0}}, en_one});
         default:     a_op = '0;
      endcase
      case (cmd.b_sel)
         B_COEFF: begin
            b_op   = BW'(coeff_ff);
            last_k = KW'(1);
         end
         B_S1_ACTIVE: begin
            b_op   = BW'(s1_act);
            last_k = KW'(BD - 1);
         end
         B_S2_ACTIVE: begin
            b_op   = BW'(s2_act);
            last_k = KW'(BD - 1);
         end
         B_COUNT: begin
            b_op   = $signed({{(BW-COUNT_BITS){1'b0}}, cnt_act});
            last_k = KW'(2);
         end
         default: begin
            b_op   = '0;
            last_k = '0;
         end
      endcase
   end

   // one 8-bit digit of B per cycle, top digit taken as signed
   assign mul_last = (k_ff == last_k);
   assign digit    = b_op[{k_ff, 3'b000} +: DIGIT_BITS];
   assign d9       = mul_last ? $signed({digit[DIGIT_BITS-1], digit})
                              : $signed({1'b0, digit});
   assign partial  = a_op * d9;
   assign part_sh  = PW'(partial) <<< {k_ff, 3'b000};

   assign ub      = (cmd.op == OP_UPD1);
   assign s1_u    = ub ? s1_ff[1]  : s1_ff[0];
   assign s2_u    = ub ? s2_ff[1]  : s2_ff[0];
   assign en_u    = ub ? en_ff[1]  : en_ff[0];
   assign cnt_u   = ub ? cnt_ff[1] : cnt_ff[0];
   assign acc_sh  = acc_ff >>> COEFF_FRAC;
   assign t_sum   = TW'(acc_sh) + TW'(x_ff) - TW'(s2_u);
   assign t_ovf   = !((&t_sum[TW-1:SB-1]) || !(|t_sum[TW-1:SB-1]));
   assign s_new   = t_ovf ? (t_sum[TW-1] ? $signed({1'b1, {(SB-1){1'b0}}})
                                         : $signed({1'b0, {(SB-1){1'b1}}}))
                          : t_sum[SB-1:0];
   assign e_sum   = EXW'(en_u) + EXW'(sq_ff);
   assign e_new   = (e_sum > EXW'({SB{1'b1}})) ? {SB{1'b1}} : e_sum[SB-1:0];
   assign cnt_new = (&cnt_u) ? cnt_u : cnt_u + 1'b1;

   assign pos_p1  = {1'b0, pos_ff} + 1'b1;
   assign sw      = (pos_p1 >= {1'b0, blen_ff});
   assign sq_prod = req_sample * req_sample;

   assign num = {q_ff, 2'b00};
   assign ge  = (rem_ff >= dsh_ff);

   always_comb begin
      coeff_in = coeff_ff;
      blen_in  = blen_ff;
      x_in     = x_ff;
      sq_in    = sq_ff;
      pos_in   = pos_ff;
      act_in   = act_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      en_in    = en_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      u_in     = u_ff;
      q_in     = q_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      dk_in    = dk_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      ratio_in = ratio_ff;
      bank_in  = bank_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_TONE_COEFF: coeff_in = $signed(csr_wdata);
            CSR_BLOCK_LEN:  blen_in  = csr_wdata;
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            x_in   = req_sample;
            sq_in  = $unsigned(sq_prod);
            pos_in = sw ? '0 : pos_p1[CSR_DATA_BITS-1:0];
            if (sw) begin
               // old active bank goes idle and restarts with this sample
               act_in = !act_ff;
               if (act_ff) begin
                  s1_in[1] = '0; s2_in[1] = '0; en_in[1] = '0; cnt_in[1] = '0;
               end else begin
                  s1_in[0] = '0; s2_in[0] = '0; en_in[0] = '0; cnt_in[0] = '0;
               end
            end
         end
         OP_MUL: begin
            k_in   = mul_last ? '0 : k_ff + 1'b1;
            acc_in = ((k_ff == '0) ? '0 : acc_ff) + part_sh;
         end
         OP_UPD0, OP_UPD1: begin
            if (ub) begin
               s2_in[1] = s1_u; s1_in[1] = s_new; en_in[1] = e_new; cnt_in[1] = cnt_new;
            end else begin
               s2_in[0] = s1_u; s1_in[0] = s_new; en_in[0] = e_new; cnt_in[0] = cnt_new;
            end
         end
         OP_UCALC: u_in = (AW'(s1_act) <<< COEFF_FRAC) - AW'(acc_ff);
         OP_QSAVE: q_in = QW'(acc_ff);
         OP_QADD:  q_in = q_ff + (QW'(acc_ff) <<< COEFF_FRAC);
         OP_DEN:   den_in = acc_ff[DW-1:0];
         OP_CHECK: begin
            neg_in = q_ff[QW-1];
            sat_in = (den_ff == '0) || (num >= (NW'(den_ff) << RATIO_BITS));
            rem_in = num;
            dsh_in = NW'(den_ff) << (RATIO_BITS - 1);
            quo_in = '0;
            dk_in  = '0;
         end
         OP_DIV: begin
            if (ge) rem_in = rem_ff - dsh_ff;
            dsh_in = dsh_ff >> 1;
            quo_in = {quo_ff[RATIO_BITS-2:0], ge};
            dk_in  = dk_ff + 1'b1;
         end
         OP_OUT: begin
            ratio_in = neg_ff ? '0 : (sat_ff ? '1 : quo_ff);
            bank_in  = act_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
         blen_ff  <= BLOCK_LEN_RESET;
         pos_ff   <= '0;
         act_ff   <= 1'b0;
         s1_ff    <= '{default: '0};
         s2_ff    <= '{default: '0};
         en_ff    <= '{default: '0};
         cnt_ff   <= '{default: '0};
         k_ff     <= '0;
         dk_ff    <= '0;
      end else begin
         coeff_ff <= coeff_in;
         blen_ff  <= blen_in;
         pos_ff   <= pos_in;
         act_ff   <= act_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         en_ff    <= en_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         dk_ff    <= dk_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      u_ff     <= u_in;
      q_ff     <= q_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      sat_ff   <= sat_in;
      ratio_ff <= ratio_in;
      bank_ff  <= bank_in;
   end

   assign status.mul_last = mul_last;
   assign status.div_last = &dk_ff;
   assign rsp_power_ratio = ratio_ff;
   assign rsp_bank_in_use = bank_ff;

endmodule

`default_nettype wire

### design/tgtd_ctrl.sv
// Controller: sequences one item through the datapath and owns the handshakes.
`default_nettype none

module tgtd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire tgtd_pkg::dp_status_type status,
   output tgtd_pkg::dp_cmd_type    cmd
);
   import tgtd_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_MC0   = 16'h0002,
      S_UP0   = 16'h0004,
      S_MC1   = 16'h0008,
      S_UP1   = 16'h0010,
      S_MS2C  = 16'h0020,
      S_UCALC = 16'h0040,
      S_MUS1  = 16'h0080,
      S_QSAVE = 16'h0100,
      S_MS2S2 = 16'h0200,
      S_QADD  = 16'h0400,
      S_MEN   = 16'h0800,
      S_DEN   = 16'h1000,
      S_CHECK = 16'h2000,
      S_DIV   = 16'h4000,
      S_OUT   = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      cmd.a_sel = A_S1_BANK0;
      cmd.b_sel = B_COEFF;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_MC0;
            end
         end
         S_MC0: begin
            cmd.op = OP_MUL;
            if (status.mul_last) state_in = S_UP0;
         end
         S_UP0: begin
            cmd.op   = OP_UPD0;
            state_in = S_MC1;
         end
         S_MC1: begin
            cmd.op    = OP_MUL;
            cmd.a_sel = A_S1_BANK1;
            if (status.mul_last) state_in = S_UP1;
         end
         S_UP1: begin
            cmd.op   = OP_UPD1;
            state_in = S_MS2C;
         end
         S_MS2C: begin
            cmd.op    = OP_MUL;
            cmd.a_sel = A_S2_ACTIVE;
            if (status.mul_last) state_in = S_UCALC;
         end
         S_UCALC: begin
            cmd.op   = OP_UCALC;
            state_in = S_MUS1;
         end
         S_MUS1: begin
            cmd.op    = OP_MUL;
            cmd.a_sel = A_U;
            cmd.b_sel = B_S1_ACTIVE;
            if (status.mul_last) state_in = S_QSAVE;
         end
         S_QSAVE: begin
            cmd.op   = OP_QSAVE;
            state_in = S_MS2S2;
         end
         S_MS2S2: begin
            cmd.op    = OP_MUL;
            cmd.a_sel = A_S2_ACTIVE;
            cmd.b_sel = B_S2_ACTIVE;
            if (status.mul_last) state_in = S_QADD;
         end
         S_QADD: begin
            cmd.op   = OP_QADD;
            state_in = S_MEN;
         end
         S_MEN: begin
            cmd.op    = OP_MUL;
            cmd.a_sel = A_ENERGY;
            cmd.b_sel = B_COUNT;
            if (status.mul_last) state_in = S_DEN;
         end
         S_DEN: begin
            cmd.op   = OP_DEN;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (status.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_OUT) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### design/tandem_goertzel_tone_detector.sv
// Top level of the tandem Goertzel tone detector.
//
// Usage:
//  - req channel: one signed audio sample per item (req_valid / req_stall).
//  - rsp channel: one result per item, power_ratio (unsigned Q16.16,
//    saturating) and bank_in_use (rsp_valid / rsp_stall).
//  - csr port: write-only; index 0 = tone_coeff (Q2.14), 1 = block_len.
//    Write only while idle.
//  - Two resonator banks see every sample; the active one flips every
//    block_len samples and the bank going idle is cleared first.
//  - One item is in work at a time; the next sample is taken only once
//    the controller is back in idle after the result is written. The
//    work per item is done by the shared 8-bit-digit multiplier (six
//    products per item) and the 32-step restoring divider.
//  - The result sits in an output register: the next sample is accepted
//    while it waits; a stalled result holds until taken, and a finished
//    follow-on result waits in the controller meanwhile.
//  - Reset (synchronous): banks, counters and position cleared, bank 0
//    active, tone_coeff = 0, block_len = 256, no result pending.
`default_nettype none

module tandem_goertzel_tone_detector #(
   parameter int SAMPLE_BITS = 16,
   parameter int STATE_BITS  = 48
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [tgtd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [tgtd_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tgtd_pkg::RATIO_BITS-1:0]        rsp_power_ratio,
   output logic                                   rsp_bank_in_use
);
   import tgtd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: handshakes and step order
   tgtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // banks, multiplier, divider, registers and result register
   tgtd_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STATE_BITS  (STATE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_sample      (req_sample),
      .cmd             (cmd),
      .status          (status),
      .rsp_power_ratio (rsp_power_ratio),
      .rsp_bank_in_use (rsp_bank_in_use)
   );

endmodule

`default_nettype wire
